// ===== rtl/hrlc_pkg.sv =====
`timescale 1ns / 1ps

package hrlc_pkg;

   typedef struct packed {
      logic [7:0] req_byte;
      logic       end_of_request;
   } req_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] path_char;
      logic [2:0] verdict;
      logic       run_last;
   } rsp_type;

   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [CNT_W-1:0]                cnt;
      rsp_type [MAX_RESULTS-1:0]       item;
   } burst_type;

   localparam logic KIND_PATH   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] VERDICT_OK          = 3'd0;
   localparam logic [2:0] VERDICT_NO_METHOD   = 3'd1;
   localparam logic [2:0] VERDICT_NO_PATH     = 3'd2;
   localparam logic [2:0] VERDICT_NO_PROTO    = 3'd3;
   localparam logic [2:0] VERDICT_NOT_GET     = 3'd4;
   localparam logic [2:0] VERDICT_NOT_HTTP11  = 3'd5;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam int METHOD_LEN = 3;
   localparam int PROTO_LEN  = 8;

   function automatic logic is_ws(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
   endfunction

   // bit 4 flags a valid hex digit, bits 3:0 its value
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] method_char(logic [1:0] i);
      logic [7:0] r;
      case (i)
         2'd0: begin
            r = 8'h47;
         end
         2'd1: begin
            r = 8'h45;
         end
         2'd2: begin
            r = 8'h54;
         end
         default: begin
            r = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic logic [7:0] proto_char(logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0: begin
            r = 8'h48;
         end
         3'd1: begin
            r = 8'h54;
         end
         3'd2: begin
            r = 8'h54;
         end
         3'd3: begin
            r = 8'h50;
         end
         3'd4: begin
            r = 8'h2F;
         end
         3'd5: begin
            r = 8'h31;
         end
         3'd6: begin
            r = 8'h2E;
         end
         3'd7: begin
            r = 8'h31;
         end
         default: begin
            r = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/hrlc_parse.sv =====
`timescale 1ns / 1ps

module hrlc_parse #(
   parameter int METHOD_MAX   = 15,
   parameter int PATH_MAX_RAW = 255,
   parameter int PROTO_MAX    = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  hrlc_pkg::req_type   req_item,
   output hrlc_pkg::burst_type burst
);

   import hrlc_pkg::*;

   localparam int LEN_MAX0 = (METHOD_MAX > PROTO_MAX) ? METHOD_MAX : PROTO_MAX;
   localparam int LEN_MAX  = (PATH_MAX_RAW > LEN_MAX0) ? PATH_MAX_RAW : LEN_MAX0;
   localparam int LEN_W    = $clog2(LEN_MAX + 1);

   localparam logic [2:0] PH_METHOD = 3'd0;
   localparam logic [2:0] PH_GAP1   = 3'd1;
   localparam logic [2:0] PH_PATH   = 3'd2;
   localparam logic [2:0] PH_GAP2   = 3'd3;
   localparam logic [2:0] PH_PROTO  = 3'd4;
   localparam logic [2:0] PH_IGNORE = 3'd5;

   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_PCT   = 2'd1;
   localparam logic [1:0] ESC_DIGIT = 2'd2;

   typedef struct packed {
      logic [2:0]       phase;
      logic [LEN_W-1:0] len;
      logic             method_match;
      logic             proto_match;
      logic [1:0]       esc;
      logic [7:0]       held;
      logic             slash_pending;
      logic             nonempty_out;
      logic             slash_seen;
      logic             cut;
      logic             done;
   } st_type;

   typedef struct packed {
      st_type    st;
      burst_type acc;
      logic      again;
   } wk_type;

   localparam st_type ST_RESET = '{
      phase: PH_METHOD, len: '0, method_match: 1'b1, proto_match: 1'b1,
      esc: ESC_NONE, held: 8'h00, slash_pending: 1'b0, nonempty_out: 1'b0,
      slash_seen: 1'b0, cut: 1'b0, done: 1'b0};

   st_type st_ff, st_in;
   wk_type wk;

   function automatic wk_type emit(wk_type w, logic kind, logic [7:0] ch, logic [2:0] v);
      rsp_type r;
      r.item_kind = kind;
      r.path_char = ch;
      r.verdict   = v;
      r.run_last  = 1'b0;
      if (w.acc.cnt < CNT_W'(MAX_RESULTS)) begin
         w.acc.item[w.acc.cnt] = r;
         w.acc.cnt = w.acc.cnt + 1'b1;
      end
      return w;
   endfunction

   function automatic wk_type put_decoded(wk_type w, logic [7:0] d);
      if (!w.st.cut) begin
         if (d == CH_QUEST || d == CH_HASH || d == CH_NUL) begin
            w.st.cut = 1'b1;
         end else if (d == CH_SLASH) begin
            w.st.slash_seen    = 1'b1;
            w.st.slash_pending = 1'b1;
         end else begin
            if (w.st.slash_pending) begin
               w = emit(w, KIND_PATH, CH_SLASH, VERDICT_OK);
               w.st.slash_pending = 1'b0;
            end
            w = emit(w, KIND_PATH, d, VERDICT_OK);
            w.st.nonempty_out = 1'b1;
         end
      end
      return w;
   endfunction

   function automatic wk_type path_byte(wk_type w, logic [7:0] c);
      logic [4:0] hc;
      logic [4:0] hh;
      logic       cont;
      hc   = hex_val(c);
      hh   = hex_val(w.st.held);
      cont = 1'b1;
      if (w.st.esc == ESC_PCT) begin
         if (hc[4]) begin
            w.st.held = c;
            w.st.esc  = ESC_DIGIT;
            cont      = 1'b0;
         end else begin
            w = put_decoded(w, CH_PCT);
            w.st.esc = ESC_NONE;
         end
      end else if (w.st.esc == ESC_DIGIT) begin
         if (hh[4] && hc[4]) begin
            w = put_decoded(w, {hh[3:0], hc[3:0]});
            w.st.esc = ESC_NONE;
            cont     = 1'b0;
         end else begin
            w = put_decoded(w, CH_PCT);
            w = put_decoded(w, w.st.held);
            w.st.esc = ESC_NONE;
         end
      end
      if (cont) begin
         if (c == CH_PCT) begin
            w.st.esc = ESC_PCT;
         end else begin
            w = put_decoded(w, c);
         end
      end
      return w;
   endfunction

   function automatic wk_type end_path(wk_type w);
      if (w.st.esc != ESC_NONE) begin
         w = put_decoded(w, CH_PCT);
         if (w.st.esc == ESC_DIGIT) begin
            w = put_decoded(w, w.st.held);
         end
         w.st.esc = ESC_NONE;
      end
      if (!w.st.cut && !w.st.nonempty_out && w.st.slash_seen) begin
         w = emit(w, KIND_PATH, CH_SLASH, VERDICT_OK);
      end
      return w;
   endfunction

   function automatic wk_type send_status(wk_type w);
      logic [2:0] v;
      if (w.st.phase == PH_METHOD && w.st.len == '0) begin
         v = VERDICT_NO_METHOD;
      end else if (w.st.phase <= PH_GAP1) begin
         v = VERDICT_NO_PATH;
      end else if (w.st.phase == PH_GAP2) begin
         v = VERDICT_NO_PROTO;
      end else if (!w.st.method_match) begin
         v = VERDICT_NOT_GET;
      end else if (!w.st.proto_match) begin
         v = VERDICT_NOT_HTTP11;
      end else begin
         v = VERDICT_OK;
      end
      w = emit(w, KIND_STATUS, 8'h00, v);
      w.st.done  = 1'b1;
      w.st.phase = PH_IGNORE;
      return w;
   endfunction

   function automatic wk_type parse_pass(wk_type w, logic [7:0] c);
      logic ws;
      ws      = is_ws(c);
      w.again = 1'b0;
      case (w.st.phase)
         PH_METHOD: begin
            if (ws) begin
               if (w.st.len == '0) begin
                  w = send_status(w);
               end else begin
                  w.st.method_match = w.st.method_match && (w.st.len == LEN_W'(METHOD_LEN));
                  w.st.phase = PH_GAP1;
                  w.st.len   = '0;
               end
            end else if (w.st.len >= LEN_W'(METHOD_MAX)) begin
               w.st.method_match = w.st.method_match && (w.st.len == LEN_W'(METHOD_LEN));
               w.st.phase = PH_PATH;
               w.st.len   = '0;
               w.again    = 1'b1;
            end else begin
               if (w.st.len >= LEN_W'(METHOD_LEN)) begin
                  w.st.method_match = 1'b0;
               end else if (c != method_char(w.st.len[1:0])) begin
                  w.st.method_match = 1'b0;
               end
               w.st.len = w.st.len + LEN_W'(1);
            end
         end
         PH_GAP1, PH_GAP2: begin
            if (!ws) begin
               w.st.phase = w.st.phase + 3'd1;
               w.st.len   = '0;
               w.again    = 1'b1;
            end
         end
         PH_PATH: begin
            if (ws) begin
               w = end_path(w);
               w.st.phase = PH_GAP2;
               w.st.len   = '0;
            end else if (w.st.len >= LEN_W'(PATH_MAX_RAW)) begin
               w = end_path(w);
               w.st.phase = PH_PROTO;
               w.st.len   = '0;
               w.again    = 1'b1;
            end else begin
               w.st.len = w.st.len + LEN_W'(1);
               w = path_byte(w, c);
            end
         end
         PH_PROTO: begin
            if (ws) begin
               w.st.proto_match = w.st.proto_match && (w.st.len == LEN_W'(PROTO_LEN));
               w = send_status(w);
            end else begin
               if (w.st.len >= LEN_W'(PROTO_LEN)) begin
                  w.st.proto_match = 1'b0;
               end else if (c != proto_char(w.st.len[2:0])) begin
                  w.st.proto_match = 1'b0;
               end
               w.st.len = w.st.len + LEN_W'(1);
               if (w.st.len >= LEN_W'(PROTO_MAX)) begin
                  w.st.proto_match = w.st.proto_match && (w.st.len == LEN_W'(PROTO_LEN));
                  w = send_status(w);
               end
            end
         end
         default: begin
            w.again = 1'b0;
         end
      endcase
      return w;
   endfunction

   always_comb begin
      wk        = '0;
      wk.st     = st_ff;
      wk        = parse_pass(wk, req_item.req_byte);
      // a full token, or a non-space byte that ends a gap, hands the byte on to the next phase
      if (wk.again) begin
         wk = parse_pass(wk, req_item.req_byte);
      end
      if (req_item.end_of_request && !wk.st.done) begin
         if (wk.st.phase == PH_METHOD && wk.st.len != '0) begin
            wk.st.method_match = wk.st.method_match && (wk.st.len == LEN_W'(METHOD_LEN));
         end
         if (wk.st.phase == PH_PATH) begin
            wk = end_path(wk);
         end
         if (wk.st.phase == PH_PROTO) begin
            wk.st.proto_match = wk.st.proto_match && (wk.st.len == LEN_W'(PROTO_LEN));
         end
         wk = send_status(wk);
      end
      if (wk.acc.cnt != '0) begin
         wk.acc.item[wk.acc.cnt - 1'b1].run_last = 1'b1;
      end
      st_in = req_item.end_of_request ? ST_RESET : wk.st;
   end

   assign burst = wk.acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_RESET;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== rtl/http_request_line_check.sv =====
`timescale 1ns / 1ps

// Checks an HTTP request line one byte per clock while rsp_ready is high. A
// request byte is taken into an input register, parsed combinationally against
// the parse state, and its results (normalised path bytes, then one status
// item per request) land in a six-deep result buffer that drains one result
// per cycle while rsp_ready is high. Bytes that cause no result or one result
// stream through at one per cycle, via the input register and then the result
// buffer. A byte that causes n > 1 results holds the input while the result
// buffer drains; the input register takes one more byte during a result stall.

module http_request_line_check #(
   parameter int METHOD_MAX   = 15,
   parameter int PATH_MAX_RAW = 255,
   parameter int PROTO_MAX    = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hrlc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hrlc_pkg::rsp_type rsp_data
);

   import hrlc_pkg::*;

   req_type          in_ff;
   logic             in_vld_ff, in_vld_in;
   rsp_type          res_ff [MAX_RESULTS];
   rsp_type          res_in [MAX_RESULTS];
   logic [CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic             fire;
   logic             pop;
   logic             take;
   burst_type        burst;

   hrlc_parse #(
      .METHOD_MAX   (METHOD_MAX),
      .PATH_MAX_RAW (PATH_MAX_RAW),
      .PROTO_MAX    (PROTO_MAX)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_item (in_ff),
      .burst    (burst)
   );

   assign rsp_valid = (res_cnt_ff != '0);
   assign rsp_data  = res_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign fire      = in_vld_ff && ((res_cnt_ff == '0) ||
                                    ((res_cnt_ff == CNT_W'(1)) && rsp_ready));
   assign req_ready = !in_vld_ff || fire;
   assign take      = req_valid && req_ready;
   assign in_vld_in = take || (in_vld_ff && !fire);

   always_comb begin
      res_in     = res_ff;
      res_cnt_in = res_cnt_ff;
      if (fire) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            res_in[i] = burst.item[i];
         end
         res_cnt_in = burst.cnt;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         res_cnt_in = res_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         res_cnt_ff <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_data;
      end
      res_ff <= res_in;
   end

endmodule
